@@ sv/fsc_pkg.sv @@
// Shared constants for the fixed-point sine/cosine pipeline.
package fsc_pkg;

  // Default turn size in angle steps (power of two, 16 to 65536).
  localparam int unsigned ANGLE_STEPS_DEFAULT = 1024;

  // Register stages in each polynomial lane.
  localparam int unsigned FSC_STAGES = 5;

  localparam int unsigned ANGLE_W = 16;
  localparam int unsigned X_W     = 8;   // Q0.8 quarter-wave abscissa
  localparam int unsigned ACC_W   = 17;  // polynomial accumulator
  localparam int unsigned OUT_W   = 10;  // Q2.8 result, two's complement

  // Taylor coefficients, pre-scaled by the basis gain.
  localparam logic [8:0] C_LIN   = 9'd479;
  localparam logic [7:0] C_CUBE  = 8'd196;
  localparam logic [4:0] C_QUINT = 5'd24;

endpackage

@@ sv/fsc_fold.sv @@
// Quadrant fold: angle to quarter-wave abscissa and sign.
module fsc_fold #(
  parameter int unsigned ANGLE_STEPS_TOTAL = fsc_pkg::ANGLE_STEPS_DEFAULT,
  parameter bit          QUARTER_SHIFT     = 1'b0
) (
  input  logic [fsc_pkg::ANGLE_W-1:0] angle,
  output logic [fsc_pkg::X_W-1:0]     x,
  output logic                        neg
);
  import fsc_pkg::*;

  localparam int unsigned TURN_BITS = $clog2(ANGLE_STEPS_TOTAL);
  localparam int unsigned QBITS     = TURN_BITS - 2;
  localparam logic [TURN_BITS-1:0] OFFS =
    QUARTER_SHIFT ? (TURN_BITS'(1) << QBITS) : '0;

  logic [TURN_BITS-1:0] idx;
  logic [1:0]           quad;
  logic [QBITS-1:0]     lcl;

  assign idx  = angle[TURN_BITS-1:0] + OFFS;
  assign quad = idx[TURN_BITS-1 -: 2];
  // odd quadrants mirror to Q-1-local
  assign lcl  = quad[0] ? ~idx[QBITS-1:0] : idx[QBITS-1:0];
  assign neg  = quad[1];

  // x = local*256/Q with Q a power of two
  generate
    if (QBITS >= X_W) begin : g_shr
      assign x = lcl[QBITS-1 -: X_W];
    end else begin : g_shl
      assign x = {lcl, {(X_W-QBITS){1'b0}}};
    end
  endgenerate

endmodule

@@ sv/fsc_lane.sv @@
// One polynomial lane: fold plus five-stage Taylor evaluation.
module fsc_lane #(
  parameter int unsigned ANGLE_STEPS_TOTAL = fsc_pkg::ANGLE_STEPS_DEFAULT,
  parameter bit          QUARTER_SHIFT     = 1'b0
) (
  input  logic                             clk,
  input  logic [fsc_pkg::FSC_STAGES-1:0]   adv,
  input  logic [fsc_pkg::ANGLE_W-1:0]      angle,
  output logic signed [fsc_pkg::OUT_W-1:0] result
);
  import fsc_pkg::*;

  logic [X_W-1:0]      fx;
  logic                fneg;

  logic [X_W-1:0]      s1_x;
  logic                s1_neg;
  logic [X_W-1:0]      s2_x, s2_x2;
  logic                s2_neg;
  logic [X_W-1:0]      s3_x, s3_x2, s3_x3;
  logic                s3_neg;
  logic [X_W-1:0]      s4_x5;
  logic [ACC_W-1:0]    s4_p;
  logic                s4_neg;

  logic [2*X_W-1:0]    sq, cu, qu;
  logic [ACC_W-1:0]    lin, cub, quint, sum;
  logic [OUT_W-1:0]    mag;

  fsc_fold #(
    .ANGLE_STEPS_TOTAL(ANGLE_STEPS_TOTAL),
    .QUARTER_SHIFT    (QUARTER_SHIFT)
  ) u_fold (
    .angle(angle),
    .x    (fx),
    .neg  (fneg)
  );

  assign sq    = s1_x * s1_x;
  assign cu    = s2_x2 * s2_x;
  assign qu    = s3_x3 * s3_x2;
  assign lin   = ACC_W'(C_LIN) * ACC_W'(s3_x);
  assign cub   = ACC_W'(C_CUBE) * ACC_W'(s3_x3);
  assign quint = ACC_W'(C_QUINT) * ACC_W'(s4_x5);
  // linear term dominates the cubic one, so p never goes negative
  assign sum   = s4_p + quint;
  assign mag   = OUT_W'(sum[ACC_W-1:8]);

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s1_x   <= fx;
      s1_neg <= fneg;
    end
    if (adv[1]) begin
      s2_x   <= s1_x;
      s2_x2  <= sq[2*X_W-1:X_W];
      s2_neg <= s1_neg;
    end
    if (adv[2]) begin
      s3_x   <= s2_x;
      s3_x2  <= s2_x2;
      s3_x3  <= cu[2*X_W-1:X_W];
      s3_neg <= s2_neg;
    end
    if (adv[3]) begin
      s4_x5  <= qu[2*X_W-1:X_W];
      s4_p   <= lin - cub;
      s4_neg <= s3_neg;
    end
    if (adv[4]) begin
      result <= s4_neg ? -$signed(mag) : $signed(mag);
    end
  end

endmodule

@@ sv/fixed_point_sine_cosine_top.sv @@
// Top level of the fixed-point sine/cosine pipeline.
// Usage:
//   Input channel angle_valid/angle_ready carries one 16-bit binary angle per
//   item; only the low log2(ANGLE_STEPS_TOTAL) bits count, so a full turn is
//   ANGLE_STEPS_TOTAL steps and larger angles wrap.
//   Output channel result_valid/result_ready carries sine and cosine in Q2.8
//   two's complement, scaled by the polynomial's basis gain of about 1.18.
//   Latency is five register stages: an accepted angle moves through them in
//   order, and result_valid rises when it reaches the last. Stages: fold,
//   square, cube, fifth power with linear/cubic terms, then final sum and
//   sign, in each of two identical lanes (sine, and cosine as sine of angle
//   plus a quarter turn). Throughput is one item per cycle while
//   result_ready is high; each stage holds one item.
//   Stalls: every stage has its own valid bit and loads whenever it is empty
//   or the stage after it moves, so while result_ready is low the pipeline
//   keeps absorbing items until all five stages are full; only then does
//   angle_ready drop. Nothing is dropped or repeated.
//   Reset clears all stage valid bits; the data registers are not reset.
module fixed_point_sine_cosine_top #(
  parameter int unsigned ANGLE_STEPS_TOTAL = fsc_pkg::ANGLE_STEPS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             angle_valid,
  output logic                             angle_ready,
  input  logic [fsc_pkg::ANGLE_W-1:0]      angle,
  output logic                             result_valid,
  input  logic                             result_ready,
  output logic signed [fsc_pkg::OUT_W-1:0] sine,
  output logic signed [fsc_pkg::OUT_W-1:0] cosine
);
  import fsc_pkg::*;

  // per-stage occupancy
  logic [FSC_STAGES-1:0] vld;
  logic [FSC_STAGES-1:0] vld_next;
  logic [FSC_STAGES-1:0] vld_in;
  // rdy[k]: stage k may load this cycle
  logic [FSC_STAGES:0]   rdy;

  assign vld_in = {vld[FSC_STAGES-2:0], angle_valid};

  always_comb begin
    rdy[FSC_STAGES] = result_ready;
    for (int k = FSC_STAGES - 1; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  always_comb begin
    for (int k = 0; k < FSC_STAGES; k++) begin
      vld_next[k] = rdy[k] ? vld_in[k] : vld[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= vld_next;
    end
  end

  assign angle_ready  = rdy[0];
  assign result_valid = vld[FSC_STAGES-1];

  fsc_lane #(
    .ANGLE_STEPS_TOTAL(ANGLE_STEPS_TOTAL),
    .QUARTER_SHIFT    (1'b0)
  ) u_sine (
    .clk   (clk),
    .adv   (rdy[FSC_STAGES-1:0]),
    .angle (angle),
    .result(sine)
  );

  fsc_lane #(
    .ANGLE_STEPS_TOTAL(ANGLE_STEPS_TOTAL),
    .QUARTER_SHIFT    (1'b1)
  ) u_cosine (
    .clk   (clk),
    .adv   (rdy[FSC_STAGES-1:0]),
    .angle (angle),
    .result(cosine)
  );

  // Input is refused only when every stage is occupied.
  a_full_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !angle_ready |-> (&vld))
    else $error("angle_ready low with an empty stage");

  // Nothing comes out right after reset.
  a_empty_after_reset: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result_valid set after reset");

  // Results stay within the scaled quarter-wave range.
  a_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (sine <= 10'sd320 && sine >= -10'sd320 &&
                      cosine <= 10'sd320 && cosine >= -10'sd320))
    else $error("sine/cosine out of range");

endmodule

@@ test/fixed_point_sine_cosine_top_tb.sv @@
// Testbench for the fixed-point sine/cosine pipeline: predicted results vs. DUT.
module fixed_point_sine_cosine_top_tb;
  import fsc_pkg::*;

  // Turn size used by the DUT instance and by the local predictor.
  localparam int unsigned STEPS = ANGLE_STEPS_DEFAULT;
  localparam int unsigned QTR   = STEPS / 4;

  // Random item count after the directed part.
  localparam int unsigned RANDOM_ITEMS = 630;

  // Receiver stall modes.
  typedef enum logic [1:0] {
    RX_OPEN    = 2'd0,  // always ready
    RX_COIN    = 2'd1,  // ready half the time
    RX_SPARSE  = 2'd2,  // ready about a quarter of the time
    RX_PATTERN = 2'd3   // rotating fixed bit pattern
  } rx_mode_t;

  // One expected sine/cosine pair, tagged with the angle that caused it.
  typedef struct {
    logic [ANGLE_W-1:0]    angle;
    logic signed [OUT_W-1:0] sine;
    logic signed [OUT_W-1:0] cosine;
  } trig_pair_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    angle_valid = 1'b0;
  logic                    angle_ready;
  logic [ANGLE_W-1:0]      angle = '0;
  logic                    result_valid;
  logic                    result_ready = 1'b0;
  logic signed [OUT_W-1:0] sine;
  logic signed [OUT_W-1:0] cosine;

  // Angles waiting to be offered, and pairs waiting to come out.
  logic [ANGLE_W-1:0] angles_pending[$];
  trig_pair_t         trig_due[$];

  // Set at each rising edge: did the input item go through on that edge.
  logic        angle_taken = 1'b0;
  int unsigned angles_accepted = 0;
  int unsigned mismatches = 0;

  fixed_point_sine_cosine_top #(
    .ANGLE_STEPS_TOTAL(STEPS)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .angle_valid (angle_valid),
    .angle_ready (angle_ready),
    .angle       (angle),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .sine        (sine),
    .cosine      (cosine)
  );

  //--------------------------------------------------------------------------
  // Predictor
  //--------------------------------------------------------------------------

  // Quarter-wave Taylor polynomial on a folded offset, truncating after each
  // power and after the final sum, exactly as the datapath does.
  function automatic logic [31:0] quarter_poly(input logic [31:0] offs);
    logic [31:0] a, x, x2, x3, x5, acc;
    a   = offs & (QTR - 1);
    x   = (a * 256) / QTR;
    x2  = (x * x) >> 8;
    x3  = (x2 * x) >> 8;
    x5  = (x3 * x2) >> 8;
    acc = 32'd479 * x + 32'd24 * x5 - 32'd196 * x3;
    return acc >> 8;
  endfunction

  // Sample of the folded wave at an angle index. Odd quadrants use the
  // mirror index Q-1-offset as is (no peak correction); lower half negates.
  function automatic logic signed [OUT_W-1:0] wave_sample(input logic [31:0] idx);
    logic [31:0] pos, quad, offs, mag;
    pos  = idx & (STEPS - 1);
    quad = (pos / QTR) & 32'd3;
    offs = pos & (QTR - 1);
    if (quad == 32'd1 || quad == 32'd3) begin
      offs = QTR - 1 - offs;
    end
    mag = quarter_poly(offs);
    if (quad >= 32'd2) begin
      mag = 32'd0 - mag;
    end
    return mag[OUT_W-1:0];
  endfunction

  //--------------------------------------------------------------------------
  // Clock and reset
  //--------------------------------------------------------------------------

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  //--------------------------------------------------------------------------
  // Stimulus: directed corners first, then random angles
  //--------------------------------------------------------------------------

  initial begin
    int unsigned pick;
    logic [ANGLE_W-1:0] a;

    // Quadrant edges, including the mirror point at the start of odd quadrants.
    angles_pending.push_back(16'd0);
    angles_pending.push_back(16'd1);
    angles_pending.push_back(ANGLE_W'(QTR - 1));
    angles_pending.push_back(ANGLE_W'(QTR));
    angles_pending.push_back(ANGLE_W'(QTR + 1));
    angles_pending.push_back(ANGLE_W'(2 * QTR - 1));
    angles_pending.push_back(ANGLE_W'(2 * QTR));
    angles_pending.push_back(ANGLE_W'(2 * QTR + 1));
    angles_pending.push_back(ANGLE_W'(3 * QTR - 1));
    angles_pending.push_back(ANGLE_W'(3 * QTR));
    angles_pending.push_back(ANGLE_W'(3 * QTR + 1));
    // Last step of the turn: the cosine offset wraps past the turn.
    angles_pending.push_back(ANGLE_W'(STEPS - 1));
    angles_pending.push_back(ANGLE_W'(STEPS - QTR));
    // Bits above the turn are ignored.
    angles_pending.push_back(ANGLE_W'(STEPS));
    angles_pending.push_back(16'hFFFF);
    angles_pending.push_back(16'hFFFF ^ ANGLE_W'(STEPS - 1));
    angles_pending.push_back(16'h8000);
    angles_pending.push_back(16'h5555);
    angles_pending.push_back(16'hAAAA);
    angles_pending.push_back(ANGLE_W'(STEPS + QTR - 1));
    angles_pending.push_back(ANGLE_W'(QTR / 2));
    angles_pending.push_back(ANGLE_W'(3 * QTR + QTR / 2));

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        a = ANGLE_W'($urandom_range(0, 65535));
      end else if (pick < 80) begin
        a = ANGLE_W'($urandom_range(0, STEPS - 1));
      end else begin
        // near a quadrant boundary, upper bits random
        a = ANGLE_W'($urandom_range(0, 3) * QTR + $urandom_range(0, 4))
            - ANGLE_W'(2);
        a = (a & ANGLE_W'(STEPS - 1)) | (ANGLE_W'($urandom) & ~ANGLE_W'(STEPS - 1));
      end
      angles_pending.push_back(a);
    end

    // Wait for every item to be taken, then for every result to come out.
    while (angles_pending.size() != 0 || angle_valid) @(posedge clk);
    while (trig_due.size() != 0) @(posedge clk);
    // Linger past the pipeline depth to catch stray results.
    repeat (4 * FSC_STAGES) @(posedge clk);

    if (mismatches == 0) begin
      $display("fixed_point_sine_cosine_top regression: pass");
    end else begin
      $display("fixed_point_sine_cosine_top regression: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("fixed_point_sine_cosine_top regression: fail");
    $finish;
  end

  //--------------------------------------------------------------------------
  // Driver: bursts of items separated by random gaps
  //--------------------------------------------------------------------------

  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;

  always @(negedge clk) begin
    logic               nxt_valid;
    logic [ANGLE_W-1:0] nxt_angle;
    nxt_valid = angle_valid;
    nxt_angle = angle;
    if (rst) begin
      nxt_valid = 1'b0;
    end else begin
      if (angle_taken) begin
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        // idle bus carries junk so stale payloads are not mistaken for data
        nxt_angle = ANGLE_W'($urandom);
        if (gap_left > 0) begin
          gap_left--;
        end else if (angles_pending.size() != 0) begin
          nxt_angle = angles_pending.pop_front();
          nxt_valid = 1'b1;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            // about a third of the bursts run back to back
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
          end
        end
      end
    end
    angle_valid <= nxt_valid;
    angle       <= nxt_angle;
  end

  //--------------------------------------------------------------------------
  // Receiver: stall pattern of its own plus two long hold-offs
  //--------------------------------------------------------------------------

  rx_mode_t    rx_mode     = RX_OPEN;
  int unsigned rx_mode_left = 40;
  logic [7:0]  rx_bits     = 8'b1011_0010;
  int unsigned hold_left   = 0;
  int unsigned holds_done  = 0;

  // Long hold-offs while the sender keeps offering: the pipeline must
  // fill all its stages and then drop angle_ready.
  always @(negedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_done == 0 && angles_accepted >= 150) begin
      hold_left  <= 60;
      holds_done <= 1;
    end else if (holds_done == 1 && angles_accepted >= 420) begin
      hold_left  <= 45;
      holds_done <= 2;
    end
  end

  always @(negedge clk) begin
    logic nxt_ready;
    nxt_ready = 1'b0;
    if (!rst && hold_left == 0) begin
      if (rx_mode_left == 0) begin
        rx_mode      = rx_mode_t'($urandom_range(0, 3));
        rx_mode_left = $urandom_range(20, 150);
        rx_bits      = 8'($urandom) | 8'h01;
      end else begin
        rx_mode_left--;
      end
      unique case (rx_mode)
        RX_OPEN:    nxt_ready = 1'b1;
        RX_COIN:    nxt_ready = ($urandom_range(0, 1) == 1);
        RX_SPARSE:  nxt_ready = ($urandom_range(0, 3) == 0);
        RX_PATTERN: begin
          nxt_ready = rx_bits[0];
          rx_bits   = {rx_bits[0], rx_bits[7:1]};
        end
      endcase
    end
    result_ready <= nxt_ready;
  end

  //--------------------------------------------------------------------------
  // Monitor: record accepted angles, check every accepted result
  //--------------------------------------------------------------------------

  always @(posedge clk) begin
    trig_pair_t want;
    if (rst) begin
      angle_taken <= 1'b0;
    end else begin
      angle_taken <= angle_valid && angle_ready;
      if (angle_valid && angle_ready) begin
        want.angle  = angle;
        want.sine   = wave_sample({16'd0, angle});
        want.cosine = wave_sample({16'd0, angle} + QTR);
        trig_due.push_back(want);
        angles_accepted++;
      end

      if (result_valid && result_ready) begin
        if (trig_due.size() == 0) begin
          if (mismatches < 10) begin
            $display("unexpected result: sine=%0d cosine=%0d", sine, cosine);
          end
          mismatches++;
        end else begin
          want = trig_due.pop_front();
          if (sine !== want.sine || cosine !== want.cosine) begin
            if (mismatches < 10) begin
              $display("mismatch angle=0x%04h: sine exp %0d got %0d, cosine exp %0d got %0d",
                       want.angle, want.sine, sine, want.cosine, cosine);
            end
            mismatches++;
          end
        end
      end
    end
  end

endmodule

@@ sim.f @@
sv/fsc_pkg.sv
sv/fsc_fold.sv
sv/fsc_lane.sv
sv/fixed_point_sine_cosine_top.sv
test/fixed_point_sine_cosine_top_tb.sv
